### design/stq_pkg.sv
`default_nettype none

package stq_pkg;

	localparam int unsigned TIME_BITS    = 25;
	localparam int unsigned DELAY_BITS   = 24;
	localparam int unsigned ELAPSED_BITS = 16;
	localparam int unsigned KIND_BITS    = 2;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_EXPIRED  = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_START,
		ST_ADD_SHIFT,
		ST_ADD_PLACE,
		ST_TICK_START,
		ST_TICK_SCAN,
		ST_EMIT_READ,
		ST_EMIT_LOAD,
		ST_RESPOND
	} state_t;

	typedef struct packed {
		logic  in_ready;
		logic  add_start;
		logic  shift_step;
		logic  place;
		logic  scan_start;
		logic  scan_hit;
		logic  emit_read;
		logic  emit_pop;
		logic  respond;
		logic  set_kind;
		kind_t kind;
		logic  tick_commit;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_action;
		logic action_tick;
		logic full;
		logic empty;
		logic shift_more;
		logic j_zero;
		logic expired;
		logic scan_more;
		logic popped_zero;
		logic popped_one;
		logic can_load;
	} stat_t;

endpackage

`default_nettype wire

### design/stq_if.sv
`default_nettype none

interface stq_req_if #(
	parameter int unsigned TAG_BITS = 8
);
	logic                                  valid;
	logic                                  ready;
	logic                                  action;
	logic [TAG_BITS-1:0]                   event_tag;
	logic [stq_pkg::DELAY_BITS-1:0]        delay_ticks;
	logic [stq_pkg::ELAPSED_BITS-1:0]      elapsed_ticks;

	modport source (output valid, action, event_tag, delay_ticks, elapsed_ticks,
		input ready);
	modport sink (input valid, action, event_tag, delay_ticks, elapsed_ticks,
		output ready);
endinterface

interface stq_rsp_if #(
	parameter int unsigned TAG_BITS = 8,
	parameter int unsigned OCC_BITS = 5
);
	logic                            valid;
	logic                            ready;
	logic [stq_pkg::KIND_BITS-1:0]   kind;
	logic [TAG_BITS-1:0]             expired_tag;
	logic                            last;
	logic [OCC_BITS-1:0]             occupancy;

	modport source (output valid, kind, expired_tag, last, occupancy, input ready);
	modport sink (input valid, kind, expired_tag, last, occupancy, output ready);
endinterface

`default_nettype wire

### design/stq_ctrl.sv
`default_nettype none

module stq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire stq_pkg::stat_t st,
	output stq_pkg::cmd_t       cmd
);

	stq_pkg::state_t state_q;
	stq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stq_pkg::ST_IDLE: begin
				if (st.in_valid) begin
					state_d = (st.in_action == stq_pkg::ACT_TICK) ?
						stq_pkg::ST_TICK_START : stq_pkg::ST_ADD_START;
				end
			end
			stq_pkg::ST_ADD_START: begin
				if (st.full) begin
					state_d = stq_pkg::ST_RESPOND;
				end else if (st.empty) begin
					state_d = stq_pkg::ST_ADD_PLACE;
				end else begin
					state_d = stq_pkg::ST_ADD_SHIFT;
				end
			end
			stq_pkg::ST_ADD_SHIFT: begin
				if (!st.shift_more || st.j_zero) begin
					state_d = stq_pkg::ST_ADD_PLACE;
				end
			end
			stq_pkg::ST_ADD_PLACE: state_d = stq_pkg::ST_RESPOND;
			stq_pkg::ST_TICK_START: begin
				state_d = st.empty ? stq_pkg::ST_RESPOND : stq_pkg::ST_TICK_SCAN;
			end
			stq_pkg::ST_TICK_SCAN: begin
				if (st.expired) begin
					if (!st.scan_more) begin
						state_d = stq_pkg::ST_EMIT_READ;
					end
				end else if (st.popped_zero) begin
					state_d = stq_pkg::ST_RESPOND;
				end else begin
					state_d = stq_pkg::ST_EMIT_READ;
				end
			end
			stq_pkg::ST_EMIT_READ: state_d = stq_pkg::ST_EMIT_LOAD;
			stq_pkg::ST_EMIT_LOAD: begin
				if (st.can_load) begin
					state_d = st.popped_one ? stq_pkg::ST_IDLE : stq_pkg::ST_EMIT_READ;
				end
			end
			stq_pkg::ST_RESPOND: begin
				if (st.can_load) begin
					state_d = stq_pkg::ST_IDLE;
				end
			end
			default: state_d = stq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.kind = stq_pkg::KIND_NONE;
		unique case (state_q)
			stq_pkg::ST_IDLE: cmd.in_ready = 1'b1;
			stq_pkg::ST_ADD_START: begin
				if (st.full) begin
					cmd.set_kind = 1'b1;
					cmd.kind     = stq_pkg::KIND_REJECTED;
				end else begin
					cmd.add_start = 1'b1;
				end
			end
			stq_pkg::ST_ADD_SHIFT: cmd.shift_step = st.shift_more;
			stq_pkg::ST_ADD_PLACE: begin
				cmd.place    = 1'b1;
				cmd.set_kind = 1'b1;
				cmd.kind     = stq_pkg::KIND_ACCEPTED;
			end
			stq_pkg::ST_TICK_START: begin
				if (st.empty) begin
					cmd.set_kind = 1'b1;
					cmd.kind     = stq_pkg::KIND_NONE;
				end else begin
					cmd.scan_start = 1'b1;
				end
			end
			stq_pkg::ST_TICK_SCAN: begin
				if (st.expired) begin
					cmd.scan_hit = 1'b1;
				end else if (st.popped_zero) begin
					cmd.set_kind = 1'b1;
					cmd.kind     = stq_pkg::KIND_NONE;
				end
			end
			stq_pkg::ST_EMIT_READ: cmd.emit_read = 1'b1;
			stq_pkg::ST_EMIT_LOAD: begin
				if (st.can_load) begin
					cmd.emit_pop    = 1'b1;
					cmd.tick_commit = st.popped_one;
				end
			end
			stq_pkg::ST_RESPOND: begin
				if (st.can_load) begin
					cmd.respond     = 1'b1;
					cmd.tick_commit = st.action_tick;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/stq_datapath.sv
`default_nettype none

module stq_datapath #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TAG_BITS    = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire stq_pkg::cmd_t cmd,
	output stq_pkg::stat_t     st,
	stq_req_if.sink            req,
	stq_rsp_if.source          rsp
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned TW = stq_pkg::TIME_BITS;
	localparam logic [AW:0]   DEPTH_V  = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		return (p == LAST_IDX) ? '0 : AW'(p + 1'b1);
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST_IDX : AW'(p - 1'b1);
	endfunction

	// Stored times are absolute deadlines against a running tick count, so a
	// tick only moves the count instead of touching every entry.
	logic [TW-1:0]       mem_time [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] mem_tag  [QUEUE_DEPTH];

	logic [TW-1:0]       rd_time_q;
	logic [TAG_BITS-1:0] rd_tag_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [AW-1:0]       wr_ptr_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       j_q;
	logic [CW-1:0]       popped_q;
	logic [TW-1:0]       now_q;

	logic                              action_q;
	logic [TAG_BITS-1:0]               tag_q;
	logic [stq_pkg::DELAY_BITS-1:0]    delay_q;
	logic [stq_pkg::ELAPSED_BITS-1:0]  elapsed_q;
	stq_pkg::kind_t                    resp_kind_q;

	logic                out_valid_q;
	stq_pkg::kind_t      out_kind_q;
	logic [TAG_BITS-1:0] out_tag_q;
	logic                out_last_q;
	logic [CW-1:0]       out_occ_q;

	logic                capture;
	logic                can_load;
	logic [AW:0]         tail_sum;
	logic [AW-1:0]       tail;
	logic [TW-1:0]       remain;
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [TW-1:0]       mem_wd_time;
	logic [TAG_BITS-1:0] mem_wd_tag;
	logic                mem_re;
	logic [AW-1:0]       mem_ra;

	assign capture  = req.valid && req.ready;
	assign can_load = !out_valid_q || rsp.ready;
	assign tail_sum = (AW + 1)'(head_q) + (AW + 1)'(count_q);
	assign tail     = (tail_sum >= DEPTH_V) ? AW'(tail_sum - DEPTH_V) : AW'(tail_sum);
	assign remain   = rd_time_q - now_q;

	always_comb begin
		st             = '0;
		st.in_valid    = req.valid;
		st.in_action   = req.action;
		st.action_tick = (action_q == stq_pkg::ACT_TICK);
		st.full        = (count_q == FULL_CNT);
		st.empty       = (count_q == '0);
		st.shift_more  = (remain > TW'(delay_q));
		st.j_zero      = (j_q == '0);
		st.expired     = (remain <= TW'(elapsed_q));
		st.scan_more   = (CW'(popped_q + 1'b1) != count_q);
		st.popped_zero = (popped_q == '0);
		st.popped_one  = (popped_q == CW'(1));
		st.can_load    = can_load;
	end

	always_comb begin
		mem_we      = cmd.shift_step || cmd.place;
		mem_wa      = wr_ptr_q;
		mem_wd_time = cmd.place ? TW'(now_q + TW'(delay_q)) : rd_time_q;
		mem_wd_tag  = cmd.place ? tag_q : rd_tag_q;
		mem_re      = cmd.add_start || cmd.shift_step || cmd.scan_start
			|| cmd.scan_hit || cmd.emit_read;
		mem_ra      = head_q;
		if (cmd.add_start) begin
			mem_ra = ring_dec(tail);
		end else if (cmd.shift_step) begin
			mem_ra = ring_dec(rd_ptr_q);
		end else if (cmd.scan_hit) begin
			mem_ra = ring_inc(rd_ptr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_time[mem_wa] <= mem_wd_time;
			mem_tag[mem_wa]  <= mem_wd_tag;
		end
		if (mem_re) begin
			rd_time_q <= mem_time[mem_ra];
			rd_tag_q  <= mem_tag[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_ptr_q <= mem_ra;
		end
		if (cmd.add_start) begin
			wr_ptr_q <= tail;
			j_q      <= CW'(count_q - 1'b1);
		end else if (cmd.shift_step) begin
			wr_ptr_q <= rd_ptr_q;
			j_q      <= CW'(j_q - 1'b1);
		end
		if (capture) begin
			action_q  <= req.action;
			tag_q     <= req.event_tag;
			delay_q   <= req.delay_ticks;
			elapsed_q <= req.elapsed_ticks;
		end
		if (cmd.set_kind) begin
			resp_kind_q <= cmd.kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			popped_q <= '0;
			now_q    <= '0;
		end else begin
			if (cmd.place) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (cmd.emit_pop) begin
				count_q <= CW'(count_q - 1'b1);
				head_q  <= ring_inc(head_q);
			end
			if (cmd.scan_start) begin
				popped_q <= '0;
			end else if (cmd.scan_hit) begin
				popped_q <= CW'(popped_q + 1'b1);
			end else if (cmd.emit_pop) begin
				popped_q <= CW'(popped_q - 1'b1);
			end
			if (cmd.tick_commit) begin
				now_q <= TW'(now_q + TW'(elapsed_q));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pop || cmd.respond) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pop) begin
			out_kind_q <= stq_pkg::KIND_EXPIRED;
			out_tag_q  <= rd_tag_q;
			out_last_q <= (popped_q == CW'(1));
			out_occ_q  <= CW'(count_q - 1'b1);
		end else if (cmd.respond) begin
			out_kind_q <= resp_kind_q;
			out_tag_q  <= '0;
			out_last_q <= 1'b1;
			out_occ_q  <= count_q;
		end
	end

	assign req.ready       = cmd.in_ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_kind_q;
	assign rsp.expired_tag = out_tag_q;
	assign rsp.last        = out_last_q;
	assign rsp.occupancy   = out_occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond queue depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_pop || cmd.respond) |-> can_load)
		else $error("result loaded over one not yet taken");

	a_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_pop |-> (popped_q != '0) && (count_q != '0))
		else $error("pop with no expired entry held");

	a_place_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |-> (count_q != FULL_CNT))
		else $error("insert into a full queue");

	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> !req.ready && $stable(count_q))
		else $error("new item taken while one is still at work");

endmodule

`default_nettype wire

### design/sorted_timeout_event_queue.sv
// Channel  Role    Payload
// req      sink    action, event_tag, delay_ticks, elapsed_ticks
// rsp      source  kind, expired_tag, last, occupancy
//
// One item at a time; reset clears the count, head pointer and tick base, not the memory.
// Add: entries are shifted one slot up (at most QUEUE_DEPTH - 1), then the new one is placed;
// a full queue is refused without a shift; one move per cycle through the write port.
// Tick: a start and scan step finds the expired entries, then each expired result is
// loaded with its tag re-read from memory; a tick with no expiry gives a single none result.
// A waiting result holds only the loading of the next one; req.ready stays high when idle.

`default_nettype none

module sorted_timeout_event_queue #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TAG_BITS    = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	stq_req_if.sink   req,
	stq_rsp_if.source rsp
);

	stq_pkg::cmd_t  cmd;
	stq_pkg::stat_t st;

	stq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	stq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.st     (st),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH           = 16;
	localparam int unsigned TAG_W           = 8;
	localparam int unsigned OCC_W           = 5;
	localparam int unsigned TIME_W          = stq_pkg::TIME_BITS;
	localparam int unsigned DELAY_W         = stq_pkg::DELAY_BITS;
	localparam int unsigned ELAPSED_W       = stq_pkg::ELAPSED_BITS;
	localparam int unsigned RANDOM_ITEMS    = 346;
	localparam int unsigned HOLD_OFF_AT     = 120;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES    = 64;
	localparam int unsigned MAX_REPORTS     = 10;

	localparam logic           A_ADD  = stq_pkg::ACT_ADD;
	localparam logic           A_TICK = stq_pkg::ACT_TICK;
	localparam stq_pkg::kind_t K_ACC  = stq_pkg::KIND_ACCEPTED;
	localparam stq_pkg::kind_t K_REJ  = stq_pkg::KIND_REJECTED;
	localparam stq_pkg::kind_t K_EXP  = stq_pkg::KIND_EXPIRED;
	localparam stq_pkg::kind_t K_NONE = stq_pkg::KIND_NONE;

	typedef struct packed {
		logic                 action;
		logic [TAG_W-1:0]     tag;
		logic [DELAY_W-1:0]   delay;
		logic [ELAPSED_W-1:0] elapsed;
	} timer_req_t;

	typedef struct packed {
		stq_pkg::kind_t    kind;
		logic [TAG_W-1:0]  tag;
		logic              last;
		logic [OCC_W-1:0]  occ;
	} timer_rsp_t;

	typedef struct packed {
		timer_req_t req;
		logic       typed;
		timer_rsp_t rsp;
	} step_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	stq_req_if #(.TAG_BITS(TAG_W)) req_ch ();
	stq_rsp_if #(.TAG_BITS(TAG_W), .OCC_BITS(OCC_W)) rsp_ch ();

	sorted_timeout_event_queue #(
		.QUEUE_DEPTH(DEPTH),
		.TAG_BITS   (TAG_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #10 clk = ~clk;

	// The queue is filled to the brim with mixed delays, including equal times and zero
	// delays, then partly drained by ticks. Rows with typed = 0 rely on the predictor.
	step_row_t directed_rows [24] = '{
		'{'{A_TICK, 8'h00, 24'h000000, 16'h0000}, 1'b1, '{K_NONE, 8'h00, 1'b1, 5'd0}},
		'{'{A_ADD,  8'hFF, 24'h000000, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd1}},
		'{'{A_TICK, 8'h00, 24'h000000, 16'h0000}, 1'b1, '{K_EXP,  8'hFF, 1'b1, 5'd0}},
		'{'{A_TICK, 8'hFF, 24'hFFFFFF, 16'hFFFF}, 1'b1, '{K_NONE, 8'h00, 1'b1, 5'd0}},
		'{'{A_ADD,  8'h00, 24'hFFFFFF, 16'hFFFF}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd1}},
		'{'{A_ADD,  8'h01, 24'h000005, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd2}},
		'{'{A_ADD,  8'h02, 24'h000005, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd3}},
		'{'{A_ADD,  8'h03, 24'h000000, 16'h1234}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd4}},
		'{'{A_ADD,  8'hA5, 24'h010000, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd5}},
		'{'{A_ADD,  8'h5A, 24'h00FFFF, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd6}},
		'{'{A_ADD,  8'h06, 24'h010000, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd7}},
		'{'{A_ADD,  8'h07, 24'h000001, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd8}},
		'{'{A_ADD,  8'h08, 24'h000005, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd9}},
		'{'{A_ADD,  8'h09, 24'h00FFFE, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd10}},
		'{'{A_ADD,  8'h0A, 24'h000000, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd11}},
		'{'{A_ADD,  8'h0B, 24'h000003, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd12}},
		'{'{A_ADD,  8'hFE, 24'hFFFFFF, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd13}},
		'{'{A_ADD,  8'h80, 24'h800000, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd14}},
		'{'{A_ADD,  8'h7F, 24'h000007, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd15}},
		'{'{A_ADD,  8'h0F, 24'h000002, 16'h0000}, 1'b1, '{K_ACC,  8'h00, 1'b1, 5'd16}},
		'{'{A_ADD,  8'h11, 24'h000009, 16'hFFFF}, 1'b1, '{K_REJ,  8'h00, 1'b1, 5'd16}},
		'{'{A_TICK, 8'h00, 24'h000000, 16'h0000}, 1'b0, '{K_ACC,  8'h00, 1'b0, 5'd0}},
		'{'{A_TICK, 8'h5A, 24'h123456, 16'hFFFF}, 1'b0, '{K_ACC,  8'h00, 1'b0, 5'd0}},
		'{'{A_TICK, 8'hC3, 24'hABCDEF, 16'hFFFF}, 1'b0, '{K_ACC,  8'h00, 1'b0, 5'd0}}
	};

	// Own copy of the timer queue, sorted by remaining time.
	logic [TIME_W-1:0] pend_time [DEPTH];
	logic [TAG_W-1:0]  pend_tag  [DEPTH];
	int unsigned       pend_count = 0;

	timer_rsp_t  expected_events [$];
	int unsigned mismatches   = 0;
	int unsigned n_adds       = 0;
	int unsigned n_ticks      = 0;
	int unsigned n_expired    = 0;
	int unsigned n_rejected   = 0;
	int unsigned most_expired = 0;

	function automatic void append_rsp(ref timer_rsp_t q [$], input timer_rsp_t r);
		q.insert(q.size(), r);
	endfunction

	function automatic void predict_queue(input timer_req_t it, ref timer_rsp_t res [$]);
		int unsigned pos;
		int unsigned popped;
		int unsigned i;
		res = {};
		if (it.action == A_ADD) begin
			if (pend_count >= DEPTH) begin
				append_rsp(res, timer_rsp_t'{K_REJ, '0, 1'b1, OCC_W'(pend_count)});
				return;
			end
			// A new entry goes behind every entry of equal or smaller time.
			pos = pend_count;
			for (i = 0; i < pend_count; i++) begin
				if (pend_time[i] > TIME_W'(it.delay)) begin
					pos = i;
					break;
				end
			end
			for (i = pend_count; i > pos; i--) begin
				pend_time[i] = pend_time[i-1];
				pend_tag[i]  = pend_tag[i-1];
			end
			pend_time[pos] = TIME_W'(it.delay);
			pend_tag[pos]  = it.tag;
			pend_count++;
			append_rsp(res, timer_rsp_t'{K_ACC, '0, 1'b1, OCC_W'(pend_count)});
			return;
		end
		popped = 0;
		while (popped < pend_count && pend_time[popped] <= TIME_W'(it.elapsed))
			popped++;
		for (i = 0; i < popped; i++)
			append_rsp(res, timer_rsp_t'{K_EXP, pend_tag[i], (i + 1 == popped),
				OCC_W'(pend_count - (i + 1))});
		for (i = popped; i < pend_count; i++) begin
			pend_time[i-popped] = pend_time[i] - TIME_W'(it.elapsed);
			pend_tag[i-popped]  = pend_tag[i];
		end
		pend_count -= popped;
		if (popped == 0)
			append_rsp(res, timer_rsp_t'{K_NONE, '0, 1'b1, OCC_W'(pend_count)});
	endfunction

	// Some stretches run without any idling so that back-to-back traffic is seen too.
	function automatic int unsigned draw_gap(input int unsigned n);
		if ((n / 32) % 4 == 3)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic timer_req_t random_item(input bit force_add);
		timer_req_t  it;
		int unsigned sel;
		it.tag     = TAG_W'($urandom);
		it.delay   = DELAY_W'($urandom);
		it.elapsed = ELAPSED_W'($urandom);
		if (force_add || $urandom_range(0, 99) < 55)
			it.action = A_ADD;
		else
			it.action = A_TICK;
		sel = $urandom_range(0, 9);
		if (it.action == A_ADD) begin
			if (sel < 6)
				it.delay = DELAY_W'($urandom_range(0, 40));
			else if (sel < 8)
				it.delay = DELAY_W'($urandom_range(0, 16'hFFFF));
			else if (sel == 8)
				it.delay = '1;
		end else begin
			if (sel < 5)
				it.elapsed = ELAPSED_W'($urandom_range(0, 20));
			else if (sel == 7)
				it.elapsed = '0;
			else if (sel == 8)
				it.elapsed = '1;
		end
		return it;
	endfunction

	task automatic offer_item(input timer_req_t it, input logic typed, input timer_rsp_t typed_rsp,
		input int unsigned gap);
		timer_rsp_t res [$];
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid         <= 1'b1;
		req_ch.action        <= it.action;
		req_ch.event_tag     <= it.tag;
		req_ch.delay_ticks   <= it.delay;
		req_ch.elapsed_ticks <= it.elapsed;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_queue(it, res);
		if (typed)
			append_rsp(expected_events, typed_rsp);
		else
			foreach (res[k])
				append_rsp(expected_events, res[k]);
		if (it.action == A_ADD) begin
			n_adds++;
			if (res[0].kind == K_REJ)
				n_rejected++;
		end else begin
			n_ticks++;
			if (res[0].kind == K_EXP) begin
				n_expired += res.size();
				if (res.size() > most_expired)
					most_expired = res.size();
			end
		end
	endtask

	function automatic void report_mismatch(input string what, input timer_rsp_t want,
		input timer_rsp_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("tb_top: %s: want kind %0d tag %02h last %0d occ %0d,",
				what, want.kind, want.tag, want.last, want.occ);
			$display("tb_top:     got kind %0d tag %02h last %0d occ %0d",
				got.kind, got.tag, got.last, got.occ);
		end
	endfunction

	function automatic void check_result();
		timer_rsp_t got;
		timer_rsp_t want;
		got = '{stq_pkg::kind_t'(rsp_ch.kind), rsp_ch.expired_tag, rsp_ch.last,
			rsp_ch.occupancy};
		if (expected_events.size() == 0) begin
			report_mismatch("result with no item pending", '0, got);
			return;
		end
		want = expected_events.pop_front();
		if (got !== want)
			report_mismatch("result mismatch", want, got);
	endfunction

	// Result side: random stalls, plus one long hold-off that backs the block up.
	initial begin
		int unsigned taken;
		int unsigned gap;
		bit          held;
		taken = 0;
		held  = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && taken == HOLD_OFF_AT) begin
				held = 1'b1;
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			gap = draw_gap(taken);
			repeat (gap) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
			check_result();
			taken++;
		end
	end

	initial begin
		int unsigned n;
		int unsigned burst;
		req_ch.valid         = 1'b0;
		req_ch.action        = A_ADD;
		req_ch.event_tag     = '0;
		req_ch.delay_ticks   = '0;
		req_ch.elapsed_ticks = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r])
			offer_item(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].rsp,
				draw_gap(r));

		// Bursts of adds can push the queue to full; single items mix adds and ticks.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				burst = $urandom_range(4, 20);
				for (int unsigned b = 0; b < burst && n < RANDOM_ITEMS; b++) begin
					offer_item(random_item(1'b1), 1'b0, '0, draw_gap(n));
					n++;
				end
			end else begin
				offer_item(random_item(1'b0), 1'b0, '0, draw_gap(n));
				n++;
			end
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;

		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d adds (%0d refused on a full queue), %0d ticks", n_adds,
			n_rejected, n_ticks);
		$display("tb_top: %0d events expired, at most %0d on one tick, %0d mismatches",
			n_expired, most_expired, mismatches);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("tb_top: timeout with %0d results outstanding", expected_events.size());
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
